/* hw/rtl/prfs_pkg.sv */
package prfs_pkg;

  typedef struct packed {
    logic       req_type;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_filter_type;
    logic       last_of_row;
    logic       last_of_image;
  } out_t;

  localparam int NUM_FILT  = 5;
  localparam int NUM_LANES = 4;

  localparam logic [2:0] FT_NONE  = 3'd0;
  localparam logic [2:0] FT_SUB   = 3'd1;
  localparam logic [2:0] FT_UP    = 3'd2;
  localparam logic [2:0] FT_AVG   = 3'd3;
  localparam logic [2:0] FT_PAETH = 3'd4;

  localparam logic REQ_PUSH  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam logic REG_WIDTH    = 1'b0;
  localparam logic REG_CHANNELS = 1'b1;

  localparam logic [2:0] CH_RGB = 3'd3;

  typedef logic [NUM_FILT-1:0][7:0] cost_vec_t;

  typedef struct packed {
    logic fire;
    logic add;
    logic close;
  } score_ctl_t;

  function automatic logic [7:0] predict(input logic [2:0] f, input logic [7:0] a,
                                         input logic [7:0] b, input logic [7:0] c);
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic [10:0] pa;
    logic [10:0] pb;
    logic [10:0] pc;
    logic [7:0] res;
    da = $signed({3'b0, b}) - $signed({3'b0, c});
    db = $signed({3'b0, a}) - $signed({3'b0, c});
    dc = da + db;
    pa = (da < 0) ? 11'(-da) : 11'(da);
    pb = (db < 0) ? 11'(-db) : 11'(db);
    pc = (dc < 0) ? 11'(-dc) : 11'(dc);
    case (f)
      FT_SUB:   res = a;
      FT_UP:    res = b;
      FT_AVG:   res = 8'(({1'b0, a} + {1'b0, b}) >> 1);
      FT_PAETH: begin
        if (pa <= pb && pa <= pc) res = a;
        else if (pb <= pc) res = b;
        else res = c;
      end
      default:  res = 8'd0;
    endcase
    return res;
  endfunction

  // min(v, 256 - v)
  function automatic logic [7:0] abs_cost(input logic [7:0] v);
    return v[7] ? 8'(-v) : v;
  endfunction

endpackage

/* hw/rtl/prfs_ram.sv */
module prfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/prfs_lane.sv */
module prfs_lane (
  input  logic                 en,
  input  logic [7:0]           x,
  input  logic [7:0]           a,
  input  logic [7:0]           b,
  input  logic [7:0]           c,
  input  logic [7:0]           ex,
  input  logic [7:0]           ea,
  input  logic [7:0]           eb,
  input  logic [7:0]           ec,
  input  logic [2:0]           efilt,
  output prfs_pkg::cost_vec_t  cost,
  output logic [7:0]           ebyte
);
  import prfs_pkg::*;

  always_comb begin
    for (int f = 0; f < NUM_FILT; f++) begin
      cost[f] = en ? abs_cost(x - predict(3'(f), a, b, c)) : 8'd0;
    end
    ebyte = ex - predict(efilt, ea, eb, ec);
  end
endmodule

/* hw/rtl/prfs_pick.sv */
module prfs_pick #(
  parameter int SCORE_W = 22
) (
  input  logic                 clk,
  input  logic                 rst,
  input  prfs_pkg::score_ctl_t ctl,
  input  prfs_pkg::cost_vec_t  lane_cost [prfs_pkg::NUM_LANES],
  output logic [2:0]           chosen
);
  import prfs_pkg::*;

  logic [NUM_FILT-1:0][9:0]        sum_a;
  logic                            a_valid;
  logic                            a_add;
  logic                            a_close;
  logic [NUM_FILT-1:0][SCORE_W-1:0] scores;
  logic [NUM_FILT-1:0][SCORE_W-1:0] fin;
  logic                            fin_valid;
  logic [2:0]                      best;
  logic [SCORE_W-1:0]              best_score;

  // lane merge
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= ctl.fire;
      a_add   <= ctl.add;
      a_close <= ctl.close;
      for (int f = 0; f < NUM_FILT; f++) begin
        sum_a[f] <= 10'(lane_cost[0][f]) + 10'(lane_cost[1][f]) +
                    10'(lane_cost[2][f]) + 10'(lane_cost[3][f]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scores    <= '0;
      fin_valid <= 1'b0;
    end else begin
      fin_valid <= a_valid && a_close;
      if (a_valid) begin
        for (int f = 0; f < NUM_FILT; f++) begin
          if (a_close) begin
            fin[f]    <= scores[f] + (a_add ? SCORE_W'(sum_a[f]) : '0);
            scores[f] <= '0;
          end else if (a_add) begin
            scores[f] <= scores[f] + SCORE_W'(sum_a[f]);
          end
        end
      end
    end
  end

  // strict less-than keeps the lowest type on a tie
  always_comb begin
    best       = FT_NONE;
    best_score = fin[0];
    for (int f = 1; f < NUM_FILT; f++) begin
      if (fin[f] < best_score) begin
        best       = 3'(f);
        best_score = fin[f];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) chosen <= FT_NONE;
    else if (fin_valid) chosen <= best;
  end
endmodule

/* hw/rtl/png_row_filter_select_core.sv */
// channel  | handshake           | payload
// in       | in_valid/in_ready   | in_data (req_type, red, green, blue, alpha)
// out      | out_valid/out_ready | out_data (out_byte, is_filter_type, last_of_row,
//          |                     |           last_of_image)
// cfg      | apb write/read      | image_width @0x0, out_channels @0x4
// one beat leaves per cycle while out_ready is high; an emitting item is 3 or 4 bytes
// (one more on column 0), and the byte-wide output register sets that rate
// after the last pixel of a row the input waits while the scores settle
// an item passes stage 1, then the job register; synchronous reset clears control only
// the line store is not cleared; out stalls back up through one job register and stage 1
module png_row_filter_select_core #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  prfs_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output prfs_pkg::out_t   out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import prfs_pkg::*;

  localparam int CW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW       = $clog2(MAX_WIDTH + 1) + 1;
  localparam int SCORE_W  = $clog2(MAX_WIDTH * NUM_LANES * 128 + 1);
  localparam logic [1:0] HOLD_CYC = 2'd2;
  localparam logic [1:0] PH_NONE  = 2'd0;
  localparam logic [1:0] PH_FIRST = 2'd1;
  localparam logic [1:0] PH_ABOVE = 2'd2;

  logic [12:0]   image_width;
  logic [2:0]    out_channels;
  logic [WW-1:0] eff_w;
  logic [CW-1:0] column;
  logic [CW-1:0] col;
  logic          row_end;
  logic [1:0]    bank_select;
  logic [1:0]    row_phase;
  logic          acc;
  logic          is_flush;
  logic          ignore;
  logic [31:0]   px;
  logic [31:0]   rdata [3];

  logic          s1_valid;
  logic          s1_push;
  logic          s1_emit;
  logic          s1_flush;
  logic          s1_rowend;
  logic          s1_col0;
  logic          s1_bpp4;
  logic [1:0]    s1_phase;
  logic [1:0]    s1_bank;
  logic [31:0]   s1_px;
  logic          s1_fire;
  logic [1:0]    hold;
  logic [31:0]   pend;
  logic [31:0]   abv;
  logic [31:0]   above_a;
  logic [31:0]   above_p;
  logic [31:0]   nb0, nb1, nb2, nb3;
  logic [2:0]    chosen;
  cost_vec_t     lane_cost [NUM_LANES];
  logic [NUM_LANES-1:0][7:0] ebyte;
  score_ctl_t    sctl;

  logic [4:0][7:0] job_bytes;
  logic [2:0]    job_n;
  logic [2:0]    job_idx;
  logic          job_valid;
  logic          job_ft;
  logic          job_rowend;
  logic          job_img;
  logic          job_last;
  logic          job_free;
  logic          load_out;
  logic [2:0]    bpp;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CHANNELS) ? 32'(out_channels) : 32'(image_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 13'd1;
      out_channels <= 3'd4;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_WIDTH) image_width <= pwdata[12:0];
      else out_channels <= pwdata[2:0];
    end
  end

  always_comb begin
    if (image_width == 13'd0) eff_w = WW'(1);
    else if (32'(image_width) > 32'(MAX_WIDTH)) eff_w = WW'(MAX_WIDTH);
    else eff_w = WW'(image_width);
    col     = (WW'(column) < eff_w) ? column : CW'(eff_w - WW'(1));
    row_end = (WW'(col) + WW'(1)) >= eff_w;
  end

  assign acc      = in_valid && in_ready;
  assign is_flush = in_data.req_type == REQ_FLUSH;
  assign ignore   = is_flush && row_phase == PH_NONE;
  assign px       = {in_data.alpha, in_data.blue, in_data.green, in_data.red};
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      column      <= '0;
      bank_select <= 2'd0;
      row_phase   <= PH_NONE;
    end else if (acc && !ignore) begin
      if (row_end) column <= '0;
      else column <= CW'(col + 1'b1);
      if (is_flush) begin
        if (row_end) row_phase <= PH_NONE;
      end else if (row_end) begin
        bank_select <= (bank_select == 2'd2) ? 2'd0 : bank_select + 2'd1;
        row_phase   <= (row_phase == PH_NONE) ? PH_FIRST : PH_ABOVE;
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_bank
    prfs_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_ram (
      .clk   (clk),
      .we    (acc && !is_flush && bank_select == 2'(g)),
      .waddr (col),
      .wdata (px),
      .re    (acc),
      .raddr (col),
      .rdata (rdata[g])
    );
  end

  // stage 1: ram data returns here
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid  <= acc && !ignore;
      s1_push   <= !is_flush;
      s1_emit   <= row_phase != PH_NONE;
      s1_flush  <= is_flush;
      s1_rowend <= row_end;
      s1_col0   <= col == '0;
      s1_bpp4   <= out_channels != CH_RGB;
      s1_phase  <= row_phase;
      s1_bank   <= bank_select;
      s1_px     <= px;
    end
  end

  always_comb begin
    case (s1_bank)
      2'd0:    begin pend = rdata[2]; abv = rdata[1]; end
      2'd1:    begin pend = rdata[0]; abv = rdata[2]; end
      default: begin pend = rdata[1]; abv = rdata[0]; end
    endcase
    above_a = (s1_phase != PH_NONE) ? pend : 32'd0;
    above_p = (s1_phase == PH_ABOVE) ? abv : 32'd0;
  end

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    prfs_lane u_lane (
      .en    (s1_push && (k < 3 || s1_bpp4)),
      .x     (s1_px[8*k +: 8]),
      .a     (nb0[8*k +: 8]),
      .b     (above_a[8*k +: 8]),
      .c     (nb1[8*k +: 8]),
      .ex    (pend[8*k +: 8]),
      .ea    (nb2[8*k +: 8]),
      .eb    (above_p[8*k +: 8]),
      .ec    (nb3[8*k +: 8]),
      .efilt (chosen),
      .cost  (lane_cost[k]),
      .ebyte (ebyte[k])
    );
  end

  assign s1_fire = s1_valid && hold == 2'd0 && (!s1_emit || job_free);

  assign sctl.fire  = s1_fire;
  assign sctl.add   = s1_push;
  assign sctl.close = s1_rowend;

  prfs_pick #(.SCORE_W(SCORE_W)) u_pick (
    .clk       (clk),
    .rst       (rst),
    .ctl       (sctl),
    .lane_cost (lane_cost),
    .chosen    (chosen)
  );

  // wait for the new filter choice before the next row starts emitting
  always_ff @(posedge clk) begin
    if (rst) hold <= 2'd0;
    else if (s1_fire && s1_push && s1_rowend) hold <= HOLD_CYC;
    else if (hold != 2'd0) hold <= hold - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nb0 <= '0; nb1 <= '0; nb2 <= '0; nb3 <= '0;
    end else if (s1_fire) begin
      if (s1_rowend) begin
        nb0 <= '0; nb1 <= '0; nb2 <= '0; nb3 <= '0;
      end else begin
        if (s1_push) begin
          nb0 <= s1_px;
          nb1 <= above_a;
        end
        if (s1_emit) begin
          nb2 <= pend;
          nb3 <= above_p;
        end
      end
    end
  end

  // job register: bytes of one item waiting to go out
  assign bpp      = s1_bpp4 ? 3'd4 : 3'd3;
  assign load_out = job_valid && (!out_valid || out_ready);
  assign job_last = job_idx == job_n - 3'd1;
  assign job_free = !job_valid || (load_out && job_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (s1_fire && s1_emit) begin
      job_valid  <= 1'b1;
      job_idx    <= 3'd0;
      job_ft     <= s1_col0;
      job_rowend <= s1_rowend;
      job_img    <= s1_flush;
      if (s1_col0) begin
        job_bytes <= {ebyte[3], ebyte[2], ebyte[1], ebyte[0], 5'd0, chosen};
        job_n     <= bpp + 3'd1;
      end else begin
        job_bytes <= {8'd0, ebyte[3], ebyte[2], ebyte[1], ebyte[0]};
        job_n     <= bpp;
      end
    end else if (load_out) begin
      if (job_last) job_valid <= 1'b0;
      else job_idx <= job_idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
      out_data  <= '{out_byte:       job_bytes[job_idx],
                     is_filter_type: job_ft && job_idx == 3'd0,
                     last_of_row:    job_rowend && job_last,
                     last_of_image:  job_img && job_rowend && job_last};
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_job_idx: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> job_idx < job_n) else $error("job index past byte count");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    hold != 2'd0 |-> !s1_fire) else $error("stage 1 fired during hold");

  a_bank: assert property (@(posedge clk) disable iff (rst)
    bank_select != 2'd3) else $error("bank select out of range");

  a_ft_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_filter_type |-> !out_data.last_of_row && out_data.out_byte <= 8'd4)
    else $error("bad filter type beat");
endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

import prfs_pkg::*;

class filter_scoreboard;
  bit [31:0]   line_mem[3*4096];
  int unsigned bank;
  int unsigned column;
  int unsigned phase;
  bit [2:0]    chosen;
  int unsigned score[5];
  bit [31:0]   nbr[4];
  int unsigned width_reg;
  int unsigned chan_reg;
  out_t        pending_bytes[$];
  int          errs;

  function void clear_row();
    for (int f = 0; f < 5; f++) score[f] = 0;
    for (int i = 0; i < 4; i++) nbr[i] = '0;
    column = 0;
  endfunction

  function void reset_state();
    bank = 0;
    phase = 0;
    chosen = FT_NONE;
    width_reg = 1;
    chan_reg = 4;
    pending_bytes.delete();
    clear_row();
  endfunction

  function int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > 4096) return 4096;
    return width_reg;
  endfunction

  function int unsigned bytes_per_px();
    return (chan_reg == 3) ? 3 : 4;
  endfunction

  function int unsigned base_of(int unsigned b);
    return (b % 3) * 4096;
  endfunction

  function bit [7:0] guess(bit [2:0] f, bit [7:0] a, bit [7:0] b, bit [7:0] c);
    int da, db, dc;
    da = (int'(b) - int'(c)); da = da < 0 ? -da : da;
    db = (int'(a) - int'(c)); db = db < 0 ? -db : db;
    dc = (int'(a) + int'(b) - 2 * int'(c)); dc = dc < 0 ? -dc : dc;
    case (f)
      FT_SUB:   return a;
      FT_UP:    return b;
      FT_AVG:   return 8'((int'(a) + int'(b)) >> 1);
      FT_PAETH: begin
        if (da <= db && da <= dc) return a;
        return (db <= dc) ? b : c;
      end
      default:  return 8'd0;
    endcase
  endfunction

  function bit [7:0] residual(bit [2:0] f, bit [7:0] x, bit [7:0] a, bit [7:0] b,
                              bit [7:0] c);
    return x - guess(f, a, b, c);
  endfunction

  function void emit_row_px(int unsigned col, bit row_end, bit img_end);
    bit [31:0] cur;
    bit [31:0] up;
    out_t      o;
    bit        lst;
    cur = line_mem[base_of(bank + 2) + col];
    up = (phase == 2) ? line_mem[base_of(bank + 1) + col] : '0;
    if (col == 0) begin
      o = '{out_byte: 8'(chosen), is_filter_type: 1'b1, last_of_row: 1'b0,
            last_of_image: 1'b0};
      pending_bytes = {pending_bytes, o};
    end
    for (int k = 0; k < bytes_per_px(); k++) begin
      lst = (k + 1 == bytes_per_px()) && row_end;
      o.out_byte = residual(chosen, cur[8*k +: 8], nbr[2][8*k +: 8], up[8*k +: 8],
                            nbr[3][8*k +: 8]);
      o.is_filter_type = 1'b0;
      o.last_of_row = lst;
      o.last_of_image = lst & img_end;
      pending_bytes = {pending_bytes, o};
    end
    nbr[2] = cur;
    nbr[3] = up;
  endfunction

  function void note_beat(in_t it);
    int unsigned w, col, best;
    bit          row_end;
    bit [31:0]   px;
    bit [31:0]   up;
    bit [7:0]    v;
    w = eff_width();
    col = (column < w) ? column : w - 1;
    row_end = (col + 1 >= w);
    if (it.req_type == REQ_FLUSH) begin
      if (phase == 0) return;
      emit_row_px(col, row_end, 1'b1);
      if (row_end) begin
        phase = 0;
        clear_row();
      end else begin
        column = col + 1;
      end
      return;
    end
    px = {it.alpha, it.blue, it.green, it.red};
    up = (phase != 0) ? line_mem[base_of(bank + 2) + col] : '0;
    if (phase != 0) emit_row_px(col, row_end, 1'b0);
    for (int f = 0; f < 5; f++) begin
      for (int k = 0; k < bytes_per_px(); k++) begin
        v = residual(3'(f), px[8*k +: 8], nbr[0][8*k +: 8], up[8*k +: 8], nbr[1][8*k +: 8]);
        score[f] += (v < 128) ? v : 256 - v;
      end
    end
    line_mem[base_of(bank) + col] = px;
    nbr[0] = px;
    nbr[1] = up;
    if (row_end) begin
      best = 0;
      for (int f = 1; f < 5; f++) if (score[f] < score[best]) best = f;
      chosen = 3'(best);
      bank = (bank + 1) % 3;
      phase = (phase == 0) ? 1 : 2;
      clear_row();
    end else begin
      column = col + 1;
    end
  endfunction

  function void check_beat(out_t got);
    out_t e;
    if (pending_bytes.size() == 0) begin
      $error("unexpected output beat: out_byte %0h", got.out_byte);
      errs++;
      return;
    end
    e = pending_bytes.pop_front();
    if (got.out_byte !== e.out_byte) begin
      $error("out_byte: expected %0h, actual %0h", e.out_byte, got.out_byte);
      errs++;
    end
    if (got.is_filter_type !== e.is_filter_type) begin
      $error("is_filter_type: expected %0b, actual %0b", e.is_filter_type,
             got.is_filter_type);
      errs++;
    end
    if (got.last_of_row !== e.last_of_row) begin
      $error("last_of_row: expected %0b, actual %0b", e.last_of_row, got.last_of_row);
      errs++;
    end
    if (got.last_of_image !== e.last_of_image) begin
      $error("last_of_image: expected %0b, actual %0b", e.last_of_image,
             got.last_of_image);
      errs++;
    end
  endfunction
endclass

module tb;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  filter_scoreboard sb = new();
  bit          quiet = 1'b0;
  int          stall_left = 0;
  longint      cycles = 0;
  int          beats_sent = 0;

  png_row_filter_select_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_beat(in_data);
    if (!rst && out_valid && out_ready) sb.check_beat(out_data);
  end

  // output back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_beat(in_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic push_px(bit [7:0] r, bit [7:0] g, bit [7:0] b, bit [7:0] a);
    send_beat('{req_type: REQ_PUSH, red: r, green: g, blue: b, alpha: a});
  endtask

  task automatic flush_px();
    in_t it;
    it = in_t'({$urandom, 1'b0});
    it.req_type = REQ_FLUSH;
    send_beat(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic reg_write(logic idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_WIDTH) sb.width_reg = val[12:0];
    else sb.chan_reg = val[2:0];
  endtask

  function automatic bit [7:0] pick(int mode, int r, int c, int k);
    bit [7:0] ends[4] = '{8'h00, 8'hff, 8'h80, 8'h7f};
    case (mode)
      0: return 8'($urandom);
      1: return 8'(c * 7 + k * 40 + $urandom_range(0, 2));   // left neighbor wins
      2: return 8'(r * 3 + k * 50 + (c % 2) * 90);           // row above wins
      default: return ends[$urandom_range(0, 3)];
    endcase
  endfunction

  // one image: full rows, an optional partial row, then the flush of the last row
  task automatic run_image(int rows, int part, int extra);
    int w, mode;
    w = sb.eff_width();
    mode = $urandom_range(0, 3);
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < w; c++)
        push_px(pick(mode, r, c, 0), pick(mode, r, c, 1), pick(mode, r, c, 2),
                pick(mode, r, c, 3));
    for (int c = 0; c < part; c++)
      push_px(pick(mode, rows, c, 0), pick(mode, rows, c, 1), pick(mode, rows, c, 2),
              pick(mode, rows, c, 3));
    for (int c = 0; c < w + extra; c++) flush_px();
    drain();
  endtask

  initial begin
    int w;
    int chans[4] = '{3, 4, 0, 7};
    sb.reset_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // nothing pending yet
    flush_px();
    push_px(8'h00, 8'h00, 8'h00, 8'h00);
    push_px(8'hff, 8'hff, 8'hff, 8'hff);
    push_px(8'h80, 8'h7f, 8'h01, 8'hfe);
    flush_px();
    flush_px();
    drain();
    reg_write(REG_WIDTH, 32'd3);
    reg_write(REG_CHANNELS, 32'd3);
    run_image(2, 2, 1);
    reg_write(REG_WIDTH, 32'd0);
    reg_write(REG_CHANNELS, 32'd7);
    run_image(2, 0, 0);
    reg_write(REG_WIDTH, 32'd4);
    reg_write(REG_CHANNELS, 32'd0);
    run_image(3, 1, 2);

    while (beats_sent < 170) begin
      if (beats_sent > 130) quiet = 1'b1;
      w = $urandom_range(1, 9);
      reg_write(REG_WIDTH, 32'(w));
      reg_write(REG_CHANNELS, 32'(chans[$urandom_range(0, 3)]));
      run_image($urandom_range(1, 4), $urandom_range(0, 1) ? $urandom_range(0, w - 1) : 0,
                $urandom_range(0, 2));
    end

    // clamped width, then a narrower width closes the partial row
    reg_write(REG_WIDTH, 32'h1fff);
    reg_write(REG_CHANNELS, 32'd4);
    for (int c = 0; c < 3; c++)
      push_px(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    drain();
    reg_write(REG_WIDTH, 32'd2);
    run_image(1, 0, 0);

    if (sb.errs == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

/* filelist.f */
hw/rtl/prfs_pkg.sv
hw/rtl/prfs_ram.sv
hw/rtl/prfs_lane.sv
hw/rtl/prfs_pick.sv
hw/rtl/png_row_filter_select_core.sv
tb/tb.sv
